/* rtl/gravity_removed_accel_filter_unit_assert.svh */
// assertion macros for the gravity removed accel filter
`ifndef GRAVITY_REMOVED_ACCEL_FILTER_UNIT_ASSERT_SVH
`define GRAVITY_REMOVED_ACCEL_FILTER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define GRAF_CHECK(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("graf assertion failed");
`define GRAF_CHECK_RST(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("graf reset assertion failed");
`else
`define GRAF_CHECK(lbl, prop)
`define GRAF_CHECK_RST(lbl, prop)
`endif
`endif

/* rtl/graf_pkg.sv */
// shared types, constants and helpers of the gravity removed accel filter
package graf_pkg;

   localparam int VEC_W   = 26;
   localparam int Q_W     = 16;
   localparam int REG_W   = 20;
   localparam int DT_W    = 16;
   localparam int MAT_W   = 34;
   localparam int MUL_A_W = 34;
   localparam int MUL_B_W = 27;
   localparam int MUL_P_W = 61;
   localparam int ACC_W   = 62;
   localparam int NUM_W   = 48;
   localparam int DIV_N_W = 49;
   localparam int DIV_D_W = 21;

   localparam logic [1:0] CSR_TAU  = 2'd0;
   localparam logic [1:0] CSR_GRAV = 2'd1;

   localparam logic [REG_W-1:0] TAU_RESET  = 20'd8500;
   localparam logic [REG_W-1:0] GRAV_RESET = 20'd642351;

   localparam logic signed [VEC_W-1:0] VEC_MAX = 26'sh1FFFFFF;
   localparam logic signed [VEC_W-1:0] VEC_MIN = 26'sh2000000;
   localparam logic signed [MAT_W-1:0] Q28_ONE = 34'sd268435456;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_QPROD,
      ST_MAT,
      ST_GRAV,
      ST_RDT,
      ST_FTAU,
      ST_DSTART,
      ST_DIV,
      ST_EARTH,
      ST_OUT
   } graf_state_type;

   typedef struct packed {
      logic               start;
      logic [DIV_N_W-1:0] dividend;
      logic [DIV_D_W-1:0] divisor;
   } graf_div_ctl_type;

   // Q.28 sum back to Q10.16, round half up, saturate
   function automatic logic signed [VEC_W-1:0] rnd_q28(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0] t;
      t = (acc + 62'sd134217728) >>> 28;
      if (t > 62'sd33554431) begin
         return VEC_MAX;
      end else if (t < -62'sd33554432) begin
         return VEC_MIN;
      end
      return t[VEC_W-1:0];
   endfunction

endpackage

/* rtl/graf_mul.sv */
// shared signed multiplier with registered product
module graf_mul (
   input  logic                                  clock,
   input  logic signed [graf_pkg::MUL_A_W-1:0]   mul_a,
   input  logic signed [graf_pkg::MUL_B_W-1:0]   mul_b,
   output logic signed [graf_pkg::MUL_P_W-1:0]   mul_p
);
   logic signed [graf_pkg::MUL_P_W-1:0] p_ff;

   always_ff @(posedge clock) begin
      p_ff <= graf_pkg::MUL_P_W'(mul_a) * graf_pkg::MUL_P_W'(mul_b);
   end

   assign mul_p = p_ff;
endmodule

/* rtl/graf_div.sv */
// restoring unsigned divider, one quotient bit per cycle
module graf_div (
   input  logic                               clock,
   input  logic                               reset,
   input  graf_pkg::graf_div_ctl_type         ctl,
   output logic                               done,
   output logic [graf_pkg::DIV_N_W-1:0]       quot
);
   logic                           busy_ff;
   logic                           done_ff;
   logic [5:0]                     cnt_ff;
   logic [graf_pkg::DIV_D_W-1:0]   rem_ff;
   logic [graf_pkg::DIV_D_W-1:0]   dsr_ff;
   logic [graf_pkg::DIV_N_W-1:0]   quo_ff;
   logic [graf_pkg::DIV_D_W:0]     rem_sh;
   logic [graf_pkg::DIV_D_W:0]     diff;

   always_comb begin
      rem_sh = {rem_ff, quo_ff[graf_pkg::DIV_N_W-1]};
      diff   = rem_sh - {1'b0, dsr_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 6'(graf_pkg::DIV_N_W - 1);
         end else if (busy_ff) begin
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 6'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         quo_ff <= ctl.dividend;
         rem_ff <= '0;
         dsr_ff <= ctl.divisor;
      end else if (busy_ff) begin
         if (!diff[graf_pkg::DIV_D_W]) begin
            rem_ff <= diff[graf_pkg::DIV_D_W-1:0];
         end else begin
            rem_ff <= rem_sh[graf_pkg::DIV_D_W-1:0];
         end
         quo_ff <= {quo_ff[graf_pkg::DIV_N_W-2:0], !diff[graf_pkg::DIV_D_W]};
      end
   end

   assign done = done_ff;
   assign quot = quo_ff;
endmodule

/* rtl/gravity_removed_accel_filter_unit.sv */
// top level: sequencer and datapath of the gravity removed accel filter
// one transaction at a time: a new request is accepted only after the response is taken
// per axis the filter divides with the serial divider, skipped when tau plus dt is zero; the
// quaternion, gravity, filter and earth products share one multiplier, then the output state
// synchronous reset: registers to defaults, filter state to zero, sequencer idle
`include "gravity_removed_accel_filter_unit_assert.svh"
module gravity_removed_accel_filter_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic signed [25:0]  req_accel_x,
   input  logic signed [25:0]  req_accel_y,
   input  logic signed [25:0]  req_accel_z,
   input  logic signed [15:0]  req_quat_w,
   input  logic signed [15:0]  req_quat_x,
   input  logic signed [15:0]  req_quat_y,
   input  logic signed [15:0]  req_quat_z,
   input  logic [15:0]         req_dt_us,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [25:0]  rsp_motion_body_x,
   output logic signed [25:0]  rsp_motion_body_y,
   output logic signed [25:0]  rsp_motion_body_z,
   output logic signed [25:0]  rsp_motion_earth_x,
   output logic signed [25:0]  rsp_motion_earth_y,
   output logic signed [25:0]  rsp_motion_earth_z,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [19:0]         csr_data
);
   graf_pkg::graf_state_type state_ff, state_in;
   logic       phase_ff, phase_in;
   logic [3:0] cnt_ff, cnt_in;
   logic [1:0] row_ff, row_in;
   logic [1:0] col_ff, col_in;

   logic [19:0] tau_ff;
   logic [19:0] grav_ff;

   logic signed [25:0] a_ff [3];
   logic signed [15:0] q_ff [4];
   logic [15:0]        dt_ff;
   logic signed [31:0] prod_ff [9];
   logic signed [33:0] m_ff [9];
   logic signed [25:0] gb_ff [3];
   logic signed [25:0] fm_ff [3];
   logic signed [25:0] earth_ff [3];
   logic signed [47:0] n_ff;
   logic signed [61:0] acc_ff;

   logic signed [33:0] mul_a;
   logic signed [26:0] mul_b;
   logic signed [60:0] mul_p;
   logic signed [15:0] qa, qb;
   logic signed [26:0] r_val;
   logic [20:0]        den;
   logic [3:0]         m_idx;
   logic [1:0]         ax;
   logic [47:0]        n_mag;
   logic               div_done;
   logic [48:0]        div_quot;
   logic signed [25:0] q_sat;
   graf_pkg::graf_div_ctl_type div_ctl;

   assign ax    = cnt_ff[1:0];
   assign den   = {1'b0, tau_ff} + {5'b0, dt_ff};
   assign m_idx = {row_ff, 1'b0} + {2'b0, row_ff} + {2'b0, col_ff};
   assign r_val = 27'(a_ff[ax]) - 27'(gb_ff[ax]);
   assign n_mag = n_ff[47] ? 48'(-n_ff) : 48'(n_ff);

   always_comb begin
      div_ctl.start    = (state_ff == graf_pkg::ST_DSTART);
      div_ctl.dividend = {1'b0, n_mag} + 49'(den[20:1]);
      div_ctl.divisor  = den;
   end

   always_comb begin
      if (n_ff[47]) begin
         q_sat = (div_quot > 49'd33554432) ? graf_pkg::VEC_MIN : 26'(-div_quot[25:0]);
      end else begin
         q_sat = (div_quot > 49'd33554431) ? graf_pkg::VEC_MAX : div_quot[25:0];
      end
   end

   // quaternion product pairs: xx yy zz xy xz yz wx wy wz
   always_comb begin
      unique case (cnt_ff)
         4'd0:    begin qa = q_ff[1]; qb = q_ff[1]; end
         4'd1:    begin qa = q_ff[2]; qb = q_ff[2]; end
         4'd2:    begin qa = q_ff[3]; qb = q_ff[3]; end
         4'd3:    begin qa = q_ff[1]; qb = q_ff[2]; end
         4'd4:    begin qa = q_ff[1]; qb = q_ff[3]; end
         4'd5:    begin qa = q_ff[2]; qb = q_ff[3]; end
         4'd6:    begin qa = q_ff[0]; qb = q_ff[1]; end
         4'd7:    begin qa = q_ff[0]; qb = q_ff[2]; end
         default: begin qa = q_ff[0]; qb = q_ff[3]; end
      endcase
   end

   graf_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   graf_div u_div (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= graf_pkg::ST_IDLE;
         phase_ff <= 1'b0;
         cnt_ff   <= '0;
         row_ff   <= '0;
         col_ff   <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      cnt_in    = cnt_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      mul_a     = '0;
      mul_b     = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         graf_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = graf_pkg::ST_QPROD;
               cnt_in   = '0;
               phase_in = 1'b0;
            end
         end
         graf_pkg::ST_QPROD: begin
            mul_a    = 34'(qa);
            mul_b    = 27'(qb);
            phase_in = !phase_ff;
            if (phase_ff) begin
               if (cnt_ff == 4'd8) begin
                  state_in = graf_pkg::ST_MAT;
               end else begin
                  cnt_in = cnt_ff + 4'd1;
               end
            end
         end
         graf_pkg::ST_MAT: begin
            state_in = graf_pkg::ST_GRAV;
            cnt_in   = '0;
         end
         graf_pkg::ST_GRAV: begin
            // gravity in body frame is the third matrix row times g
            mul_a    = m_ff[4'd6 + cnt_ff];
            mul_b    = 27'(signed'({1'b0, grav_ff}));
            phase_in = !phase_ff;
            if (phase_ff) begin
               if (cnt_ff == 4'd2) begin
                  state_in = graf_pkg::ST_RDT;
                  cnt_in   = '0;
               end else begin
                  cnt_in = cnt_ff + 4'd1;
               end
            end
         end
         graf_pkg::ST_RDT: begin
            mul_a    = 34'(r_val);
            mul_b    = 27'(signed'({1'b0, dt_ff}));
            phase_in = !phase_ff;
            if (phase_ff) begin
               state_in = graf_pkg::ST_FTAU;
            end
         end
         graf_pkg::ST_FTAU: begin
            mul_a    = 34'(fm_ff[ax]);
            mul_b    = 27'(signed'({1'b0, tau_ff}));
            phase_in = !phase_ff;
            if (phase_ff) begin
               if (den != '0) begin
                  state_in = graf_pkg::ST_DSTART;
               end else if (cnt_ff == 4'd2) begin
                  state_in = graf_pkg::ST_EARTH;
                  row_in   = '0;
                  col_in   = '0;
               end else begin
                  state_in = graf_pkg::ST_RDT;
                  cnt_in   = cnt_ff + 4'd1;
               end
            end
         end
         graf_pkg::ST_DSTART: begin
            state_in = graf_pkg::ST_DIV;
         end
         graf_pkg::ST_DIV: begin
            if (div_done) begin
               if (cnt_ff == 4'd2) begin
                  state_in = graf_pkg::ST_EARTH;
                  row_in   = '0;
                  col_in   = '0;
               end else begin
                  state_in = graf_pkg::ST_RDT;
                  cnt_in   = cnt_ff + 4'd1;
               end
            end
         end
         graf_pkg::ST_EARTH: begin
            mul_a    = m_ff[m_idx];
            mul_b    = 27'(fm_ff[col_ff]);
            phase_in = !phase_ff;
            if (phase_ff) begin
               if (col_ff == 2'd2) begin
                  col_in = '0;
                  if (row_ff == 2'd2) begin
                     state_in = graf_pkg::ST_OUT;
                  end else begin
                     row_in = row_ff + 2'd1;
                  end
               end else begin
                  col_in = col_ff + 2'd1;
               end
            end
         end
         graf_pkg::ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = graf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = graf_pkg::ST_IDLE;
         end
      endcase
   end

   // configuration registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         tau_ff  <= graf_pkg::TAU_RESET;
         grav_ff <= graf_pkg::GRAV_RESET;
      end else if (csr_valid) begin
         if (csr_index == graf_pkg::CSR_TAU) begin
            tau_ff <= csr_data;
         end else if (csr_index == graf_pkg::CSR_GRAV) begin
            grav_ff <= csr_data;
         end
      end
   end

   // filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         fm_ff[0] <= '0;
         fm_ff[1] <= '0;
         fm_ff[2] <= '0;
      end else if (state_ff == graf_pkg::ST_DIV && div_done) begin
         fm_ff[ax] <= q_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == graf_pkg::ST_IDLE && req_valid) begin
         a_ff[0] <= req_accel_x;
         a_ff[1] <= req_accel_y;
         a_ff[2] <= req_accel_z;
         q_ff[0] <= req_quat_w;
         q_ff[1] <= req_quat_x;
         q_ff[2] <= req_quat_y;
         q_ff[3] <= req_quat_z;
         dt_ff   <= req_dt_us;
      end
      if (state_ff == graf_pkg::ST_QPROD && phase_ff) begin
         prod_ff[cnt_ff] <= mul_p[31:0];
      end
      if (state_ff == graf_pkg::ST_MAT) begin
         m_ff[0] <= graf_pkg::Q28_ONE - ((34'(prod_ff[1]) + 34'(prod_ff[2])) <<< 1);
         m_ff[1] <= (34'(prod_ff[3]) - 34'(prod_ff[8])) <<< 1;
         m_ff[2] <= (34'(prod_ff[4]) + 34'(prod_ff[7])) <<< 1;
         m_ff[3] <= (34'(prod_ff[3]) + 34'(prod_ff[8])) <<< 1;
         m_ff[4] <= graf_pkg::Q28_ONE - ((34'(prod_ff[0]) + 34'(prod_ff[2])) <<< 1);
         m_ff[5] <= (34'(prod_ff[5]) - 34'(prod_ff[6])) <<< 1;
         m_ff[6] <= (34'(prod_ff[4]) - 34'(prod_ff[7])) <<< 1;
         m_ff[7] <= (34'(prod_ff[5]) + 34'(prod_ff[6])) <<< 1;
         m_ff[8] <= graf_pkg::Q28_ONE - ((34'(prod_ff[0]) + 34'(prod_ff[1])) <<< 1);
         acc_ff  <= '0;
      end
      if (state_ff == graf_pkg::ST_GRAV && phase_ff) begin
         gb_ff[ax] <= graf_pkg::rnd_q28(62'(mul_p));
      end
      if (state_ff == graf_pkg::ST_RDT && phase_ff) begin
         n_ff <= mul_p[47:0];
      end
      if (state_ff == graf_pkg::ST_FTAU && phase_ff) begin
         n_ff <= n_ff + mul_p[47:0];
      end
      if (state_ff == graf_pkg::ST_EARTH && phase_ff) begin
         if (col_ff == 2'd2) begin
            earth_ff[row_ff] <= graf_pkg::rnd_q28(acc_ff + 62'(mul_p));
            acc_ff           <= '0;
         end else begin
            acc_ff <= acc_ff + 62'(mul_p);
         end
      end
   end

   assign rsp_motion_body_x  = fm_ff[0];
   assign rsp_motion_body_y  = fm_ff[1];
   assign rsp_motion_body_z  = fm_ff[2];
   assign rsp_motion_earth_x = earth_ff[0];
   assign rsp_motion_earth_y = earth_ff[1];
   assign rsp_motion_earth_z = earth_ff[2];

   `GRAF_CHECK(a_ready_excl, !(req_ready && rsp_valid))
   `GRAF_CHECK(a_accept_busy, req_valid && req_ready |=> !req_ready)
   `GRAF_CHECK(a_rsp_to_idle, rsp_valid && rsp_ready |=> req_ready)
   `GRAF_CHECK_RST(a_reset_idle, reset |=> (req_ready && !rsp_valid))
endmodule

/* test/gravity_removed_accel_filter_unit_checker.sv */
// checker for the gravity removed accel filter: predicts and compares results
`timescale 1ns / 1ps
module gravity_removed_accel_filter_unit_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic signed [25:0] req_accel_x,
   input  logic signed [25:0] req_accel_y,
   input  logic signed [25:0] req_accel_z,
   input  logic signed [15:0] req_quat_w,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   input  logic [15:0]        req_dt_us,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [25:0] rsp_motion_body_x,
   input  logic signed [25:0] rsp_motion_body_y,
   input  logic signed [25:0] rsp_motion_body_z,
   input  logic signed [25:0] rsp_motion_earth_x,
   input  logic signed [25:0] rsp_motion_earth_y,
   input  logic signed [25:0] rsp_motion_earth_z,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [19:0]        csr_data,
   output int                 fail_count,
   output int                 pending_count
);
   typedef struct packed {
      logic signed [25:0] bx, by, bz, ex, ey, ez;
   } motion_type;

   motion_type motion_q[$];
   longint tau_reg, grav_reg;
   longint filt[3];

   assign pending_count = motion_q.size();

   function automatic longint sat26(longint v);
      if (v > 64'sd33554431) return 64'sd33554431;
      if (v < -64'sd33554432) return -64'sd33554432;
      return v;
   endfunction

   // round half up from Q.28, floor shift on signed value
   function automatic longint from_q28(longint acc);
      return sat26((acc + (64'sd1 <<< 27)) >>> 28);
   endfunction

   function automatic longint round_div(longint n, longint d);
      longint mag, qt;
      mag = (n < 0) ? -n : n;
      qt = (mag + d / 2) / d;
      return (n < 0) ? -qt : qt;
   endfunction

   task automatic predict_motion();
      longint a[3], q[4], m[3][3], gb[3], e[3];
      longint den, dt, r;
      motion_type res;
      a[0] = req_accel_x; a[1] = req_accel_y; a[2] = req_accel_z;
      q[0] = req_quat_w; q[1] = req_quat_x; q[2] = req_quat_y; q[3] = req_quat_z;
      dt = req_dt_us;
      m[0][0] = (64'sd1 <<< 28) - 2 * (q[2]*q[2] + q[3]*q[3]);
      m[0][1] = 2 * (q[1]*q[2] - q[0]*q[3]);
      m[0][2] = 2 * (q[1]*q[3] + q[0]*q[2]);
      m[1][0] = 2 * (q[1]*q[2] + q[0]*q[3]);
      m[1][1] = (64'sd1 <<< 28) - 2 * (q[1]*q[1] + q[3]*q[3]);
      m[1][2] = 2 * (q[2]*q[3] - q[0]*q[1]);
      m[2][0] = 2 * (q[1]*q[3] - q[0]*q[2]);
      m[2][1] = 2 * (q[2]*q[3] + q[0]*q[1]);
      m[2][2] = (64'sd1 <<< 28) - 2 * (q[1]*q[1] + q[2]*q[2]);
      for (int i = 0; i < 3; i++) gb[i] = from_q28(m[2][i] * grav_reg);
      den = tau_reg + dt;
      if (den > 0) begin
         for (int i = 0; i < 3; i++) begin
            r = a[i] - gb[i];
            filt[i] = sat26(round_div(r * dt + filt[i] * tau_reg, den));
         end
      end
      for (int i = 0; i < 3; i++)
         e[i] = from_q28(m[i][0]*filt[0] + m[i][1]*filt[1] + m[i][2]*filt[2]);
      res.bx = 26'(filt[0]); res.by = 26'(filt[1]); res.bz = 26'(filt[2]);
      res.ex = 26'(e[0]); res.ey = 26'(e[1]); res.ez = 26'(e[2]);
      motion_q.push_back(res);
   endtask

   task automatic report(string fld, longint exp_v, longint act_v);
      fail_count++;
      if (fail_count <= 10)
         $display("mismatch %s: expected %0d actual %0d", fld, exp_v, act_v);
   endtask

   always @(posedge clock) begin
      motion_type want;
      if (reset) begin
         tau_reg = graf_pkg::TAU_RESET;
         grav_reg = graf_pkg::GRAV_RESET;
         filt[0] = 0; filt[1] = 0; filt[2] = 0;
         motion_q.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (motion_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("mismatch: result with none expected");
            end else begin
               want = motion_q.pop_front();
               if (want.bx !== rsp_motion_body_x) report("body_x", want.bx, rsp_motion_body_x);
               if (want.by !== rsp_motion_body_y) report("body_y", want.by, rsp_motion_body_y);
               if (want.bz !== rsp_motion_body_z) report("body_z", want.bz, rsp_motion_body_z);
               if (want.ex !== rsp_motion_earth_x)
                  report("earth_x", want.ex, rsp_motion_earth_x);
               if (want.ey !== rsp_motion_earth_y)
                  report("earth_y", want.ey, rsp_motion_earth_y);
               if (want.ez !== rsp_motion_earth_z)
                  report("earth_z", want.ez, rsp_motion_earth_z);
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == graf_pkg::CSR_TAU) tau_reg = csr_data;
            else if (csr_index == graf_pkg::CSR_GRAV) grav_reg = csr_data;
         end
         if (req_valid && req_ready) predict_motion();
      end
   end
endmodule

/* test/gravity_removed_accel_filter_unit_tb.sv */
// testbench top: stimulus, register phases and verdict for the accel filter
`timescale 1ns / 1ps
module gravity_removed_accel_filter_unit_tb;
   localparam int LATENCY = 220;
   localparam longint CYCLE_LIMIT = 3000000;
   // index with no register behind it
   localparam logic [1:0] CSR_SPARE = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0, rsp_ready = 1'b0, csr_valid = 1'b0;
   logic req_ready, rsp_valid, csr_ready;
   logic signed [25:0] req_accel_x = '0, req_accel_y = '0, req_accel_z = '0;
   logic signed [15:0] req_quat_w = '0, req_quat_x = '0, req_quat_y = '0, req_quat_z = '0;
   logic [15:0] req_dt_us = '0;
   logic signed [25:0] rsp_motion_body_x, rsp_motion_body_y, rsp_motion_body_z;
   logic signed [25:0] rsp_motion_earth_x, rsp_motion_earth_y, rsp_motion_earth_z;
   logic [1:0] csr_index = '0;
   logic [19:0] csr_data = '0;
   int fail_count, pending_count;
   longint cycle_count = 0;
   bit calm = 1'b0;

   always #5 clock = ~clock;

   gravity_removed_accel_filter_unit DUT (.*);
   gravity_removed_accel_filter_unit_checker monitor (.*);

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // result side backpressure
   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= calm || ($urandom_range(99) >= 22);
   end

   task automatic write_reg(logic [1:0] idx, logic [19:0] val);
      @(negedge clock);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_sample(logic signed [25:0] ax, ay, az,
                              logic signed [15:0] qw, qx, qy, qz, logic [15:0] dt);
      @(negedge clock);
      if (!calm)
         while ($urandom_range(99) < 22) @(negedge clock);
      req_accel_x <= ax; req_accel_y <= ay; req_accel_z <= az;
      req_quat_w <= qw; req_quat_x <= qx; req_quat_y <= qy; req_quat_z <= qz;
      req_dt_us <= dt;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic drain();
      while (pending_count != 0) @(negedge clock);
      repeat (LATENCY) @(negedge clock);
   endtask

   function automatic logic signed [25:0] rand_accel();
      case ($urandom_range(5))
         0: return 26'sh1FFFFFF;
         1: return 26'sh2000000;
         2: return 26'($urandom);
         default: return $signed(26'($urandom_range(1400000))) - 26'sd700000;
      endcase
   endfunction

   // mostly components within unit range, sometimes raw noise
   task automatic random_sample();
      logic signed [15:0] qw, qx, qy, qz;
      logic [15:0] dt;
      if ($urandom_range(9) < 7) begin
         qw = $signed(16'($urandom_range(32768))) - 16'sd16384;
         qx = $signed(16'($urandom_range(16384))) - 16'sd8192;
         qy = $signed(16'($urandom_range(16384))) - 16'sd8192;
         qz = $signed(16'($urandom_range(16384))) - 16'sd8192;
      end else begin
         qw = 16'($urandom); qx = 16'($urandom); qy = 16'($urandom); qz = 16'($urandom);
      end
      case ($urandom_range(9))
         0: dt = 16'd0;
         1: dt = 16'hFFFF;
         2: dt = 16'($urandom);
         default: dt = 16'($urandom_range(2000, 1));
      endcase
      send_sample(rand_accel(), rand_accel(), rand_accel(), qw, qx, qy, qz, dt);
   endtask

   logic [19:0] tau_set[6] = '{20'd8500, 20'd0, 20'hFFFFF, 20'd1, 20'd100000, 20'd2000};
   logic [19:0] grav_set[6] = '{20'd642351, 20'hFFFFF, 20'd0, 20'd1, 20'd300000, 20'd642351};

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, identity, zero interval, non-unit quaternion
      send_sample(26'sd0, 26'sd0, 26'sd642351,
                  16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'd1000);
      send_sample(26'sh1FFFFFF, 26'sh1FFFFFF, 26'sh1FFFFFF,
                  16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'hFFFF);
      send_sample(26'sh2000000, 26'sh2000000, 26'sh2000000,
                  16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'd1);
      send_sample(26'sd1000, -26'sd1000, 26'sd5000,
                  16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'd0);
      send_sample(-26'sd5, 26'sd7, 26'sd9,
                  16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'd500);
      send_sample(26'sd123456, -26'sd654321, 26'sd0,
                  16'sd11585, 16'sd0, 16'sd11585, 16'sd0, 16'hFFFF);
      send_sample(26'sd0, 26'sd0, 26'sd0,
                  16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'd1000);
      send_sample(26'sh1FFFFFF, 26'sh2000000, 26'sd0,
                  16'sh7FFF, 16'sh8000, 16'sd0, 16'sh7FFF, 16'd2);
      drain();
      write_reg(graf_pkg::CSR_TAU, 20'd0);
      write_reg(graf_pkg::CSR_GRAV, 20'hFFFFF);
      write_reg(CSR_SPARE, 20'h12345);
      send_sample(26'sd100, 26'sd200, 26'sd300,
                  16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'd0);
      send_sample(26'sh1FFFFFF, 26'sd0, 26'sh2000000,
                  16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'd7);
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         write_reg(graf_pkg::CSR_TAU, tau_set[phase]);
         write_reg(graf_pkg::CSR_GRAV, grav_set[phase]);
         calm = (phase == 3);
         for (int n = 0; n < 300; n++) random_sample();
         drain();
      end
      calm = 1'b0;

      if (fail_count == 0 && pending_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule

/* filelist.f */
+incdir+rtl
rtl/graf_pkg.sv
rtl/graf_mul.sv
rtl/graf_div.sv
rtl/gravity_removed_accel_filter_unit.sv
test/gravity_removed_accel_filter_unit_checker.sv
test/gravity_removed_accel_filter_unit_tb.sv
